### hw/rtl/msss_pkg.sv
// ----------------------------------------------------------------------------
// msss_pkg
// Shared constants, types and the segment font for the display scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package msss_pkg;

  localparam int unsigned DigitCount = 10;
  localparam int unsigned DigitIdxW  = (DigitCount > 1) ? $clog2(DigitCount) : 1;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  localparam logic [3:0] WindowReset = 4'd3;
  localparam logic [7:0] DashPattern = 8'b01000000;
  localparam logic signed [15:0] NumberMax = 16'sd99;

  typedef enum logic [1:0] {
    FuncChar   = 2'd0,
    FuncNumber = 2'd1,
    FuncClear  = 2'd2,
    FuncTick   = 2'd3
  } func_e;

  // One scan tick as handed from front to back.
  typedef struct packed {
    logic       has_off;
    logic       has_on;
    logic [3:0] off_addr;
    logic [3:0] on_addr;
    logic [7:0] pattern;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic [9:0][7:0] NumFont = {
    8'h7B, 8'h7F, 8'h31, 8'h5F, 8'h5B, 8'h72, 8'h79, 8'h6D, 8'h30, 8'h3F
  };

  localparam logic [25:0][7:0] AlphaFont = {
    8'h00, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h31, 8'h5B, 8'h44, 8'h00,
    8'h73, 8'h3F, 8'h37, 8'h00, 8'h0E, 8'h00, 8'h00, 8'h00, 8'h76, 8'h5F,
    8'h00, 8'h4F, 8'h7C, 8'h00, 8'h00, 8'h77
  };

  function automatic logic [7:0] font_lookup(logic [7:0] c);
    logic [7:0] pat;
    logic [7:0] off;
    pat = 8'h00;
    off = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      off = c - 8'h30;
      pat = NumFont[off[3:0]];
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      off = c - 8'h41;
      pat = AlphaFont[off[4:0]];
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      off = c - 8'h61;
      pat = AlphaFont[off[4:0]];
    end else if (c == 8'h2D) begin
      pat = DashPattern;
    end
    return pat;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/msss_in_if.sv
// ----------------------------------------------------------------------------
// msss_in_if
// Command channel: valid/ready with the command fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface msss_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [3:0]         digit_index;
  logic [7:0]         char_code;
  logic signed [15:0] number_value;

  modport source (output valid, func, digit_index, char_code, number_value, input ready);
  modport sink   (input valid, func, digit_index, char_code, number_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/msss_out_if.sv
// ----------------------------------------------------------------------------
// msss_out_if
// Digit command channel: valid/ready with address, segments and flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface msss_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit_address;
  logic [7:0] segment_pattern;
  logic       drive_on;
  logic       last_of_run;

  modport source (output valid, digit_address, segment_pattern, drive_on, last_of_run,
                  input ready);
  modport sink   (input valid, digit_address, segment_pattern, drive_on, last_of_run,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/msss_front.sv
// ----------------------------------------------------------------------------
// msss_front
// Takes commands, keeps the digit store, window and scan position, and
// turns each scan tick into a job for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module msss_front
  import msss_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  msss_in_if.sink         in_i,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_wdata_i,
  input  wire q_status_t  q_status_i,
  output logic            push_o,
  output job_t            job_o
);

  logic [7:0] store_q [DigitCount];
  logic [7:0] store_d [DigitCount];
  logic [4:0] pos_q, pos_d;
  logic [3:0] window_q;

  logic       accept;
  func_e      func;
  logic [4:0] idx_lo, idx_hi;
  logic [7:0] pat_lo, pat_hi;
  logic       num_bad;
  logic [6:0] num7;
  logic [14:0] tens_prod;
  logic [3:0] tens, ones;
  logic [7:0] tens10;
  logic [5:0] run;
  logic [4:0] pos_inc;
  logic [4:0] off_pos;
  logic       has_off, has_on;

  assign in_i.ready = !q_status_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign func       = func_e'(in_i.func);

  // Two-digit split: tens = n*205 >> 11 holds for 0..99.
  assign num7      = in_i.number_value[6:0];
  assign tens_prod = {8'd0, num7} * 15'd205;
  assign tens      = tens_prod[14:11];
  assign tens10    = {4'd0, tens} * 8'd10;
  assign ones      = 4'(({1'b0, num7} - tens10));
  assign num_bad   = (in_i.number_value < 16'sd0) || (in_i.number_value > NumberMax);

  assign idx_lo = {1'b0, in_i.digit_index};
  assign idx_hi = idx_lo + 5'd1;

  // Tick classification
  assign run     = 6'(DigitCount) + {2'd0, window_q};
  assign off_pos = pos_q - {1'b0, window_q};
  assign has_off = (pos_q >= {1'b0, window_q}) && ({1'b0, off_pos} < 6'(DigitCount));
  assign has_on  = {1'b0, pos_q} < 6'(DigitCount);
  assign pos_inc = pos_q + 5'd1;

  always_comb begin
    pat_lo  = in_i.func[0] ? (num_bad ? DashPattern : NumFont[tens])
                           : font_lookup(in_i.char_code);
    pat_hi  = num_bad ? DashPattern : NumFont[ones];
    store_d = store_q;
    pos_d   = pos_q;
    push_o  = 1'b0;
    job_o.has_off  = has_off;
    job_o.has_on   = has_on;
    job_o.off_addr = off_pos[3:0];
    job_o.on_addr  = pos_q[3:0];
    job_o.pattern  = has_on ? store_q[pos_q[DigitIdxW-1:0]] : 8'h00;
    if (accept) begin
      unique case (func)
        FuncChar: begin
          if (idx_lo < 5'(DigitCount)) store_d[idx_lo[DigitIdxW-1:0]] = pat_lo;
        end
        FuncNumber: begin
          if (idx_lo < 5'(DigitCount)) store_d[idx_lo[DigitIdxW-1:0]] = pat_lo;
          if (idx_hi < 5'(DigitCount)) store_d[idx_hi[DigitIdxW-1:0]] = pat_hi;
        end
        FuncClear: begin
          for (int i = 0; i < DigitCount; i++) store_d[i] = 8'h00;
        end
        FuncTick: begin
          push_o = has_off || has_on;
          pos_d  = ({1'b0, pos_inc} >= run) ? 5'd0 : pos_inc;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DigitCount; i++) store_q[i] <= NumFont[i % 10];
      pos_q    <= 5'd0;
      window_q <= WindowReset;
    end else begin
      store_q <= store_d;
      pos_q   <= pos_d;
      if (cfg_we_i) window_q <= cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/msss_queue.sv
// ----------------------------------------------------------------------------
// msss_queue
// Small job FIFO between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module msss_queue
  import msss_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire job_t  job_i,
  input  wire logic  pop_i,
  output job_t       head_o,
  output q_status_t  status_o
);

  job_t                 mem_q [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueAw:0]     count_q;
  logic                 do_push, do_pop;

  assign status_o.full  = (count_q == (QueueAw+1)'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/msss_back.sv
// ----------------------------------------------------------------------------
// msss_back
// Expands each tick job into its off and on commands, one per cycle while
// out_o is ready and a job is queued, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msss_back
  import msss_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire job_t      head_i,
  input  wire q_status_t q_status_i,
  output logic           pop_o,
  msss_out_if.source     out_o
);

  logic       valid_q;
  logic       off_sent_q, off_sent_d;
  logic [3:0] addr_q, addr_d;
  logic [7:0] pat_q, pat_d;
  logic       on_q, on_d;
  logic       last_q, last_d;
  logic       load;
  logic       send_off;

  assign load     = (!valid_q || out_o.ready) && !q_status_i.empty;
  assign send_off = head_i.has_off && !off_sent_q;

  always_comb begin
    off_sent_d = off_sent_q;
    pop_o      = 1'b0;
    if (send_off) begin
      addr_d = head_i.off_addr;
      pat_d  = 8'h00;
      on_d   = 1'b0;
      last_d = !head_i.has_on;
    end else begin
      addr_d = head_i.on_addr;
      pat_d  = head_i.pattern;
      on_d   = 1'b1;
      last_d = 1'b1;
    end
    if (load) begin
      if (send_off && head_i.has_on) begin
        off_sent_d = 1'b1;
      end else begin
        off_sent_d = 1'b0;
        pop_o      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      off_sent_q <= 1'b0;
    end else begin
      off_sent_q <= off_sent_d;
      if (load) valid_q <= 1'b1;
      else if (out_o.ready) valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      addr_q <= addr_d;
      pat_q  <= pat_d;
      on_q   <= on_d;
      last_q <= last_d;
    end
  end

  assign out_o.valid           = valid_q;
  assign out_o.digit_address   = addr_q;
  assign out_o.segment_pattern = pat_q;
  assign out_o.drive_on        = on_q;
  assign out_o.last_of_run     = last_q;

endmodule

`default_nettype wire

### hw/rtl/multiplexed_seven_segment_scanner.sv
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_scanner
// Digit store and scan sequencer for a multiplexed seven-segment display.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake     Carries
// in_i      in   valid/ready   func, digit_index, char_code, number_value
// out_o     out  valid/ready   digit_address, segment_pattern, drive_on, last_of_run
// cfg       in   cfg_we_i      lit_window (cfg_wdata_i), no read-back
//
// Writes and clears are registered into the store when accepted; they produce no
// output transaction. A scan tick is classified in the front end (off/on
// commands, pattern snapshot) and queued; the back end issues one command
// per cycle while out_o is ready through its output register, so a tick
// needing both commands costs two output transactions and a single-command
// tick one. The 2-entry job queue sets how far the front runs ahead; input
// ready drops only while it is full. Reset is asynchronous, active low, and
// restores the store to 0..9, position 0 and a window of 3.
// ----------------------------------------------------------------------------
`default_nettype none

module multiplexed_seven_segment_scanner
  import msss_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  msss_in_if.sink         in_i,
  msss_out_if.source      out_o,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_wdata_i
);

  // Front to queue
  logic      push;
  job_t      job;
  // Queue to back
  job_t      head;
  logic      pop;
  q_status_t q_status;

  // Store, window, position and tick classification
  msss_front u_front (
    .clk_i,
    .rst_ni,
    .in_i,
    .cfg_we_i,
    .cfg_wdata_i,
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (job)
  );

  // Decouples accepting ticks from draining commands
  msss_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i   (push),
    .job_i    (job),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  // Off command first (when present), then on command (when present); the final one is flagged last
  msss_back u_back (
    .clk_i,
    .rst_ni,
    .head_i     (head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_o
  );

endmodule

`default_nettype wire
